// File: rtl/fifs_pkg.sv
`default_nettype none
package fifs_pkg;
    localparam int unsigned TdataInW = 64;
    localparam int unsigned TdataOutW = 128;

    localparam int unsigned DblFracBits = 52;
    localparam int unsigned SglFracBits = 23;
    localparam logic [10:0] DblExpMax = 11'h7ff;
    localparam logic [7:0] SglExpMax = 8'hff;
    localparam logic [10:0] DblBias = 11'd1023;
    localparam logic [7:0] SglBias = 8'd127;

    // Split result of one operand
    typedef struct packed {
        logic [63:0] integral;
        logic [63:0] fraction;
    } t_split;

    // Highest set bit of a 52-bit word
    function automatic logic [5:0] top_bit52(input logic [51:0] v);
        logic [5:0] t;
        t = '0;
        for (int i = 0; i < 52; i++) begin
            if (v[i]) begin
                t = 6'(i);
            end
        end
        return t;
    endfunction
endpackage
`default_nettype wire

// File: rtl/fifs_dbl_split.sv
`default_nettype none
module fifs_dbl_split
    import fifs_pkg::*;
(
    input  wire  [63:0] i_x,
    output t_split      o_res
);
    logic        sgn;
    logic [10:0] ef;
    logic [51:0] frac;
    logic [10:0] e;
    logic [51:0] below;
    logic [51:0] low;
    logic [5:0]  t;
    logic [51:0] norm;
    logic [10:0] enew;

    assign sgn   = i_x[63];
    assign ef    = i_x[62:52];
    assign frac  = i_x[51:0];
    assign e     = ef - DblBias;
    assign below = {52{1'b1}} >> e[5:0];
    assign low   = frac & below;
    assign t     = top_bit52(low);
    assign norm  = low << (6'd52 - t);
    assign enew  = ef + 11'(t) - 11'd52;

    // Pick the special case or the renormalized difference
    always_comb begin
        if (ef == DblExpMax) begin
            o_res.integral = i_x;
            o_res.fraction = (frac != '0) ? i_x : {sgn, 63'd0};
        end else if (ef < DblBias) begin
            o_res.integral = {sgn, 63'd0};
            o_res.fraction = i_x;
        end else if (e >= 11'd52) begin
            o_res.integral = i_x;
            o_res.fraction = {sgn, 63'd0};
        end else begin
            o_res.integral = {i_x[63:52], frac & ~below};
            o_res.fraction = (low == '0) ? {sgn, 63'd0} : {sgn, enew, norm};
        end
    end
endmodule
`default_nettype wire

// File: rtl/fifs_sgl_split.sv
`default_nettype none
module fifs_sgl_split
    import fifs_pkg::*;
(
    input  wire  [31:0] i_x,
    output t_split      o_res
);
    logic        sgn;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [7:0]  e;
    logic [22:0] below;
    logic [22:0] low;
    logic [5:0]  t;
    logic [22:0] norm;
    logic [7:0]  enew;

    assign sgn   = i_x[31];
    assign ef    = i_x[30:23];
    assign frac  = i_x[22:0];
    assign e     = ef - SglBias;
    assign below = {23{1'b1}} >> e[4:0];
    assign low   = frac & below;
    assign t     = top_bit52({29'd0, low});
    assign norm  = low << (5'd23 - t[4:0]);
    assign enew  = ef + 8'(t) - 8'd23;

    // Pick the special case or the renormalized difference
    always_comb begin
        if (ef == SglExpMax) begin
            o_res.integral = {32'd0, i_x};
            o_res.fraction = {32'd0, (frac != '0) ? i_x : {sgn, 31'd0}};
        end else if (ef < SglBias) begin
            o_res.integral = {32'd0, sgn, 31'd0};
            o_res.fraction = {32'd0, i_x};
        end else if (e >= 8'd23) begin
            o_res.integral = {32'd0, i_x};
            o_res.fraction = {32'd0, sgn, 31'd0};
        end else begin
            o_res.integral = {32'd0, i_x[31:23], frac & ~below};
            o_res.fraction = {32'd0,
                              (low == '0) ? {sgn, 31'd0} : {sgn, enew, norm}};
        end
    end
endmodule
`default_nettype wire

// File: rtl/float_integer_fraction_split.sv
// Channel   Dir  tdata (low bit up)                      tuser
// s_axis    in   value_bits[63:0]                        is_single
// m_axis    out  integral_bits[63:0], fraction_bits      -
// One item per cycle while the output is not stalled; input register, then result register.
// Both stages are plain pipeline registers, each advanced by its own enable (adv_in, adv_out).
// Reset clears the valid bits only; payload registers hold anything.
// A stalled output holds; input is taken while the input register is empty or the result stage advances.
`default_nettype none
module float_integer_fraction_split
    import fifs_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [TdataInW-1:0]  s_axis_tdata,  // value_bits
    input  wire                  s_axis_tuser,  // is_single
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [TdataOutW-1:0] m_axis_tdata   // integral_bits, fraction_bits
);
    logic        r_in_vld;
    logic [63:0] r_x;
    logic        r_single;
    logic        r_out_vld;
    t_split      r_res;
    t_split      n_res;
    t_split      dbl_res;
    t_split      sgl_res;
    logic        adv_out;
    logic        adv_in;

    assign adv_out = !r_out_vld || m_axis_tready;
    assign adv_in  = !r_in_vld || adv_out;
    assign s_axis_tready = adv_in;

    fifs_dbl_split u_dbl (.i_x(r_x), .o_res(dbl_res));
    fifs_sgl_split u_sgl (.i_x(r_x[31:0]), .o_res(sgl_res));

    assign n_res = r_single ? sgl_res : dbl_res;

    // Advance input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv_in) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (adv_in && s_axis_tvalid) begin
            r_x      <= s_axis_tdata;
            r_single <= s_axis_tuser;
        end
    end

    // Advance result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv_out) begin
            r_out_vld <= r_in_vld;
        end
        if (adv_out && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_res.fraction, r_res.integral};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv_out |=> r_out_vld)
        else $error("item lost between stages");
endmodule
`default_nettype wire
